>>> rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int TOTAL_PAGES = 4096;
    localparam int ORDER_COUNT = 13;
    localparam int PAGE_BYTES  = 4096;
    localparam int PG_W        = $clog2(TOTAL_PAGES);
    localparam int LINK_W      = PG_W + 1;
    localparam int ORD_W       = $clog2(ORDER_COUNT);
    localparam int PB_W        = $clog2(PAGE_BYTES);
    localparam int POOL_W      = 25;
    localparam int OFS_W       = 24;
    localparam int ORDMEM_W    = ORD_W + 1;
    localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(TOTAL_PAGES);
    localparam logic [POOL_W-1:0] POOL_RESET = 25'd16777216;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [LINK_W-1:0] t_link;

    // Block size in bytes for one order; saturates above the field width.
    function automatic logic [POOL_W:0] order_bytes(input logic [ORD_W-1:0] ord);
        logic [POOL_W+16:0] v;
        v = (POOL_W+17)'(PAGE_BYTES) << ord;
        order_bytes = (v > (POOL_W+17)'({1'b0, {POOL_W{1'b1}}})) ?
            {1'b1, {POOL_W{1'b0}}} : v[POOL_W:0];
    endfunction

endpackage

>>> rtl/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/buddy_page_allocator.sv
// Buddy page allocator: one free list per order, links held in block RAMs.
// Time from accept to result valid grows with each split on an allocate, and on a free
// with each list node walked past the head and each merge; failures return early.
// Throughput: one command at a time; the next word is accepted after the result is taken.
// Reset (sync, active low) and every pool_bytes write run a rebuild: a clear of all
// TOTAL_PAGES entries, then a build pass down through every order, before accepting commands.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [bpa_pkg::POOL_W-1:0] i_cfg_pool_bytes,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [bpa_pkg::POOL_W-1:0] i_request_bytes,
    input  logic [bpa_pkg::OFS_W-1:0]  i_free_offset,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [bpa_pkg::OFS_W-1:0]  o_block_offset,
    output logic                     o_failed
);
    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,  // sweep memories
        S_BUILD  = 16'h0002,  // push initial blocks
        S_IDLE   = 16'h0004,
        S_APOP   = 16'h0008,  // pick fit and source order, latch head page
        S_APOPW  = 16'h0010,  // fix head after pop
        S_ASPLIT = 16'h0020,  // push right half
        S_ADONE  = 16'h0040,
        S_FRD    = 16'h0080,  // read in_use/order
        S_FCHK   = 16'h0100,
        S_FWALK  = 16'h0200,  // issue read of next link
        S_FWAIT  = 16'h0400,
        S_FUNL   = 16'h0800,  // unlink buddy: read prev/next
        S_FUNL2  = 16'h1000,
        S_FPUSH  = 16'h2000,
        S_OUT    = 16'h4000,
        S_PUSHP  = 16'h8000   // second write of a push (prev of old head)
    } t_state;

    t_state r_state;
    t_state r_ret;  // state after a push completes; also marks the caller of S_FWAIT

    // memories: next, prev, order+in_use
    logic              nx_we, pv_we, om_we;
    logic [PG_W-1:0]   nx_wa, pv_wa, om_wa, nx_ra, pv_ra, om_ra;
    t_link             nx_wd, pv_wd, nx_rd, pv_rd;
    logic [ORDMEM_W-1:0] om_wd, om_rd;

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(TOTAL_PAGES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    bpa_ram #(.WIDTH(LINK_W), .DEPTH(TOTAL_PAGES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    // bit ORD_W = in_use, low bits = order
    bpa_ram #(.WIDTH(ORDMEM_W), .DEPTH(TOTAL_PAGES)) u_ord (
        .i_clk(i_clk), .i_we(om_we), .i_waddr(om_wa), .i_wdata(om_wd),
        .i_raddr(om_ra), .o_rdata(om_rd));

    t_link               r_head [ORDER_COUNT];  // fixed per-order registers
    logic [POOL_W-1:0]   r_pool;
    logic [POOL_W:0]     r_left;
    logic [LINK_W:0]     r_bpg;                 // build page cursor
    logic [PG_W:0]       r_clr;
    logic [ORD_W-1:0]    r_ord, r_src;
    logic [PG_W-1:0]     r_pg, r_bud;
    t_link               r_cur, r_nxt;
    logic [ORD_W-1:0]    r_push_ord;
    logic [PG_W-1:0]     r_push_pg;
    logic [POOL_W-1:0]   r_req;
    logic [OFS_W-1:0]    r_fofs;
    logic [PG_W:0]       r_steps;
    logic                r_ovalid;
    logic [OFS_W-1:0]    r_oofs;
    logic                r_ofail;

    // smallest fitting order, first non-empty list at/above it
    logic [ORD_W-1:0] fit_ord;
    logic             fit_ok;
    logic [ORD_W-1:0] src_ord;
    logic             src_ok;
    always_comb begin
        fit_ord = '0;
        fit_ok  = 1'b0;
        for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            if ({1'b0, r_req} <= order_bytes(ORD_W'(k))) begin
                fit_ord = ORD_W'(k);
                fit_ok  = 1'b1;
            end
        end
        src_ord = '0;
        src_ok  = 1'b0;
        for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            if (ORD_W'(k) >= fit_ord && r_head[k] != NIL_PAGE) begin
                src_ord = ORD_W'(k);
                src_ok  = 1'b1;
            end
        end
    end

    logic [PG_W:0] free_page;
    assign free_page = (PG_W+1)'(r_fofs >> PB_W);

    logic [LINK_W:0] build_sz;
    assign build_sz = (LINK_W+1)'(1) << r_ord;

    logic [PG_W:0] right_pg;
    assign right_pg = {1'b0, r_pg} + ((PG_W+1)'(1) << (r_src - 1'b1));

    logic [PG_W:0] bud_full;
    assign bud_full = {1'b0, r_pg ^ (PG_W'(1) << r_ord)};

    assign o_cfg_ready    = (r_state == S_IDLE) && !r_ovalid;
    assign o_stall        = !((r_state == S_IDLE) && !r_ovalid && !i_cfg_valid);
    assign o_valid        = r_ovalid;
    assign o_block_offset = r_oofs;
    assign o_failed       = r_ofail;

    // memory port drive
    always_comb begin
        nx_we = 1'b0; pv_we = 1'b0; om_we = 1'b0;
        nx_wa = r_push_pg; pv_wa = r_push_pg; om_wa = r_pg;
        nx_wd = NIL_PAGE; pv_wd = NIL_PAGE; om_wd = '0;
        nx_ra = r_pg; pv_ra = r_pg; om_ra = r_pg;
        case (r_state)
            S_CLEAR: begin
                nx_we = 1'b1; pv_we = 1'b1; om_we = 1'b1;
                nx_wa = r_clr[PG_W-1:0]; pv_wa = r_clr[PG_W-1:0];
                om_wa = r_clr[PG_W-1:0];
            end
            S_ASPLIT, S_FPUSH, S_BUILD: begin
                // push head write: next=old head, prev=NIL
                if (r_state == S_BUILD ? (r_left >= order_bytes(r_ord)
                        && r_bpg < (LINK_W+1)'(TOTAL_PAGES)) : 1'b1) begin
                    nx_we = 1'b1; pv_we = 1'b1;
                    nx_wa = (r_state == S_BUILD) ? r_bpg[PG_W-1:0] :
                            (r_state == S_ASPLIT) ? right_pg[PG_W-1:0] : r_pg;
                    pv_wa = nx_wa;
                    nx_wd = (r_state == S_BUILD) ? r_head[r_ord] :
                            (r_state == S_ASPLIT) ? r_head[r_src - 1'b1] : r_head[r_ord];
                    pv_wd = NIL_PAGE;
                end
                if (r_state == S_FPUSH) begin
                    om_we = 1'b1; om_wa = r_pg; om_wd = {1'b0, r_ord};
                end
            end
            S_APOPW: begin
                // head popped: new head's prev -> NIL
                pv_we = (r_ret == S_APOPW) && (nx_rd != NIL_PAGE);
                pv_wa = nx_rd[PG_W-1:0];
                pv_wd = NIL_PAGE;
            end
            S_PUSHP: begin
                pv_we = (r_cur != NIL_PAGE);
                pv_wa = r_cur[PG_W-1:0];
                pv_wd = {1'b0, r_push_pg};
            end
            S_APOP: begin
                nx_ra = r_pg;
            end
            S_ADONE: begin
                om_we = 1'b1; om_wa = r_pg; om_wd = {1'b1, r_ord};
            end
            S_FRD: begin
                om_ra = free_page[PG_W-1:0];
            end
            S_FCHK: begin
                om_we = (free_page < (PG_W+1)'(TOTAL_PAGES)) && om_rd[ORD_W];
                om_wa = free_page[PG_W-1:0];
                om_wd = {1'b0, om_rd[ORD_W-1:0]};
            end
            S_FWALK: begin
                nx_ra = r_cur[PG_W-1:0];
            end
            S_FUNL: begin
                nx_ra = r_bud; pv_ra = r_bud;
            end
            S_FUNL2: begin
                nx_we = (pv_rd != NIL_PAGE);
                nx_wa = pv_rd[PG_W-1:0]; nx_wd = nx_rd;
                pv_we = (nx_rd != NIL_PAGE);
                pv_wa = nx_rd[PG_W-1:0]; pv_wd = pv_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_clr    <= '0;
            r_pool   <= POOL_RESET;
            r_ovalid <= 1'b0;
            for (int k = 0; k < ORDER_COUNT; k++) r_head[k] <= NIL_PAGE;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (PG_W+1)'(TOTAL_PAGES - 1)) begin
                        r_state <= S_BUILD;
                        r_ord   <= ORD_W'(ORDER_COUNT - 1);
                        r_bpg   <= '0;
                        r_left  <= ({1'b0, r_pool} < (POOL_W+1)'(TOTAL_PAGES * PAGE_BYTES))
                                   ? {1'b0, r_pool} : (POOL_W+1)'(TOTAL_PAGES * PAGE_BYTES);
                        for (int k = 0; k < ORDER_COUNT; k++) r_head[k] <= NIL_PAGE;
                    end
                end
                S_BUILD: begin
                    // build pushes onto empty lists, so no back-link write
                    if (r_left >= order_bytes(r_ord)
                            && r_bpg < (LINK_W+1)'(TOTAL_PAGES)) begin
                        r_head[r_ord] <= r_bpg[LINK_W-1:0];
                        r_bpg  <= r_bpg + build_sz;
                        r_left <= r_left - order_bytes(r_ord);
                    end
                    if (r_ord == '0) r_state <= S_IDLE;
                    else r_ord <= r_ord - 1'b1;
                end
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_pool  <= i_cfg_pool_bytes;
                        r_clr   <= '0;
                        r_state <= S_CLEAR;
                    end else if (i_valid && !o_stall) begin
                        r_req   <= i_request_bytes;
                        r_fofs  <= i_free_offset;
                        r_state <= (i_cmd == CMD_ALLOC) ? S_APOP : S_FRD;
                    end
                end
                S_APOP: begin
                    if (!fit_ok || !src_ok) begin
                        r_oofs <= '0; r_ofail <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_ord   <= fit_ord;
                        r_src   <= src_ord;
                        r_pg    <= r_head[src_ord][PG_W-1:0];
                        r_state <= S_APOPW;
                    end
                end
                S_APOPW: begin
                    // nx_rd was read with stale address; reread via wait
                    r_state <= S_FWAIT;
                    r_ret   <= S_APOPW;
                    if (r_ret == S_APOPW) begin
                        r_head[r_src] <= nx_rd;
                        r_cur   <= nx_rd;
                        r_state <= (r_src > r_ord) ? S_ASPLIT : S_ADONE;
                        r_ret   <= S_IDLE;
                    end
                end
                S_ASPLIT: begin
                    r_head[r_src - 1'b1] <= {1'b0, right_pg[PG_W-1:0]};
                    r_cur     <= r_head[r_src - 1'b1];
                    r_push_pg <= right_pg[PG_W-1:0];
                    r_src     <= r_src - 1'b1;
                    r_state   <= S_PUSHP;
                    r_ret     <= (r_src - 1'b1 > r_ord) ? S_ASPLIT : S_ADONE;
                end
                S_PUSHP: begin
                    r_state <= r_ret;
                end
                S_ADONE: begin
                    r_oofs  <= OFS_W'({r_pg, {PB_W{1'b0}}});
                    r_ofail <= 1'b0;
                    r_state <= S_OUT;
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (free_page >= (PG_W+1)'(TOTAL_PAGES) || !om_rd[ORD_W]) begin
                        r_oofs <= '0; r_ofail <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_pg  <= free_page[PG_W-1:0];
                        r_ord <= (om_rd[ORD_W-1:0] >= ORD_W'(ORDER_COUNT)) ?
                                 ORD_W'(ORDER_COUNT - 1) : om_rd[ORD_W-1:0];
                        r_state <= S_FPUSH;
                        r_ret   <= S_FCHK;  // marks: start buddy search
                        r_state <= S_FWAIT;
                        r_cur   <= NIL_PAGE;
                        r_steps <= '0;
                    end
                end
                S_FWAIT: begin
                    if (r_ret == S_APOPW) begin
                        r_state <= S_APOPW;
                    end else if (r_ret == S_FCHK) begin
                        // new search at r_ord
                        if (r_ord == ORD_W'(ORDER_COUNT - 1)
                                || bud_full >= (PG_W+1)'(TOTAL_PAGES)) begin
                            r_state <= S_FPUSH;
                        end else begin
                            r_bud   <= bud_full[PG_W-1:0];
                            r_cur   <= r_head[r_ord];
                            r_steps <= '0;
                            r_ret   <= S_FWALK;
                            r_state <= S_FWALK;
                            if (r_head[r_ord] == NIL_PAGE) r_state <= S_FPUSH;
                            else if (r_head[r_ord] == {1'b0, bud_full[PG_W-1:0]})
                                r_state <= S_FUNL;
                        end
                    end else begin
                        // next link arrived
                        if (nx_rd == NIL_PAGE
                                || r_steps == (PG_W+1)'(TOTAL_PAGES - 1)) begin
                            r_state <= S_FPUSH;
                        end else begin
                            r_cur   <= nx_rd;
                            r_steps <= r_steps + 1'b1;
                            r_state <= (nx_rd == {1'b0, r_bud}) ? S_FUNL : S_FWALK;
                        end
                    end
                end
                S_FWALK: r_state <= S_FWAIT;
                S_FUNL:  r_state <= S_FUNL2;
                S_FUNL2: begin
                    if (pv_rd == NIL_PAGE) r_head[r_ord] <= nx_rd;
                    if (r_bud < r_pg) r_pg <= r_bud;
                    r_ord   <= r_ord + 1'b1;
                    r_ret   <= S_FCHK;
                    r_state <= S_FWAIT;
                end
                S_FPUSH: begin
                    r_head[r_ord] <= {1'b0, r_pg};
                    r_cur     <= r_head[r_ord];
                    r_push_pg <= r_pg;
                    r_oofs    <= '0;
                    r_ofail   <= 1'b0;
                    r_ret     <= S_OUT;
                    r_state   <= S_PUSHP;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_IDLE && r_ovalid))
        else $error("result not raised");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_oofs)))
        else $error("result dropped");
endmodule
